// File: rtl/core/adf_pkg.sv
// Shared types and constants for the allpass delay filter.
// No dependencies; imported by adf_resync and allpass_delay_filter.
package adf_pkg;

    // Default number of words in the delay memory
    localparam int unsigned DEPTH_DEFAULT = 1024;

    // Sample and register field widths
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned CFG_W    = 10;
    localparam int unsigned LEN_W    = CFG_W + 1;

    // Register reset values
    localparam logic [CFG_W-1:0] LOOP_END_RESET = '1;

    // Q31 limits
    localparam logic signed [SAMPLE_W-1:0] Q31_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] Q31_MIN = 32'sh8000_0000;

    // Register indices on the configuration port (word address)
    typedef enum logic [1:0] {
        REG_GAIN     = 2'd0,
        REG_DELAY    = 2'd1,
        REG_LOOP_END = 2'd2
    } t_reg_idx;

    // Read index re-synchronisation sequencer
    typedef enum logic [1:0] {
        RS_IDLE,
        RS_DELAY,
        RS_INDEX
    } t_rs_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rs_status;

endpackage

// File: rtl/core/adf_resync.sv
// Read index re-synchronisation: a shared shift-and-subtract remainder unit.
// Depends on adf_pkg (widths, sequencer state type, status struct).
module adf_resync (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [adf_pkg::CFG_W-1:0]     i_delay,
    input  logic [adf_pkg::LEN_W-1:0]     i_len,
    input  logic [adf_pkg::CFG_W-1:0]     i_wr_idx,
    output logic [adf_pkg::CFG_W-1:0]     o_rd_idx,
    output adf_pkg::t_rs_status           o_status
);
    import adf_pkg::*;

    localparam int unsigned CNT_W = $clog2(LEN_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(LEN_W - 1);

    t_rs_state        r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [LEN_W-1:0] r_div, n_div;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [LEN_W-1:0] r_len;
    logic [CFG_W-1:0] r_wr_idx;
    logic             r_done, n_done;

    logic [LEN_W-1:0] trial;
    logic [LEN_W-1:0] step_rem;
    logic [LEN_W-1:0] step_div;
    logic [LEN_W-1:0] idx_sum;

    // One remainder bit per cycle: shift in the next dividend bit, subtract if it fits
    assign trial    = {r_rem[LEN_W-2:0], r_div[LEN_W-1]};
    assign step_rem = (trial >= r_len) ? (trial - r_len) : trial;
    assign step_div = {r_div[LEN_W-2:0], 1'b0};

    // Second pass dividend: write index plus length minus the reduced delay
    assign idx_sum = LEN_W'(r_wr_idx) + r_len - step_rem;

    // Sequence both passes
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_div   = r_div;
        n_rem   = r_rem;
        n_done  = 1'b0;
        case (r_state)
            RS_IDLE: begin
                n_state = RS_IDLE;
            end
            RS_DELAY: begin
                n_rem = step_rem;
                n_div = step_div;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    n_state = RS_INDEX;
                    n_div   = idx_sum;
                    n_rem   = '0;
                    n_cnt   = '0;
                end
            end
            RS_INDEX: begin
                n_rem = step_rem;
                n_div = step_div;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    n_state = RS_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = RS_IDLE;
            end
        endcase
        // A new delay word restarts the whole calculation
        if (i_start) begin
            n_state = RS_DELAY;
            n_div   = LEN_W'(i_delay);
            n_rem   = '0;
            n_cnt   = '0;
            n_done  = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Hold the datapath and the operands captured at start
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_div <= n_div;
        r_rem <= n_rem;
        if (i_start) begin
            r_len    <= i_len;
            r_wr_idx <= i_wr_idx;
        end
    end

    // The remainder is below the loop length, so it fits the index width
    assign o_rd_idx = r_rem[CFG_W-1:0];
    assign o_status = '{busy: (r_state != RS_IDLE) || r_done, done: r_done};

endmodule

// File: rtl/core/allpass_delay_filter.sv
// Schroeder allpass over a circular delay memory, Q31 samples, one result word per input
// word. A sample is accepted every cycle unless the output word is held or a configuration
// write is in progress; its result passes stage 1, stage 2 and the output register. The only
// other exception is a read index one position behind the write index (delay modulo loop
// length of one, or a loop of one entry), where the read-modify-write loop through the gain
// multipliers holds off the next sample until the previous one leaves stage 1. The memory
// has one read and one write port with a registered read; the last entry written is
// forwarded. Reset needs no clearing pass: a fill count marks entries never written, which
// read as zero. Writing the delay register stalls the input while a shared shift-and-subtract
// unit recomputes the read index modulo the loop length. Depends on adf_pkg and adf_resync.
module allpass_delay_filter #(
    parameter int unsigned DEPTH = adf_pkg::DEPTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [adf_pkg::SAMPLE_W-1:0]  i_sample_in,
    // Output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [adf_pkg::SAMPLE_W-1:0]  o_sample_out,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import adf_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned XW = (AW < CFG_W) ? AW : CFG_W;
    localparam logic [CFG_W-1:0] END_MAX =
        (DEPTH > (1 << CFG_W)) ? {CFG_W{1'b1}} : CFG_W'(DEPTH - 1);

    // Configuration registers
    logic signed [SAMPLE_W-1:0] r_gain;
    logic [CFG_W-1:0]           r_delay;
    logic [CFG_W-1:0]           r_loop_end;

    // Indices and fill count
    logic [XW-1:0] r_wr_idx;
    logic [XW-1:0] r_rd_idx;
    logic [XW:0]   r_fill;

    // Delay memory
    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    // Stage 1: read data returns
    logic                       r_s1_valid;
    logic signed [SAMPLE_W-1:0] r_s1_x;
    logic [XW-1:0]              r_s1_w;
    logic [XW-1:0]              r_s1_r;
    logic                       r_s1_filled;

    // Stage 2: products registered, feedback and output formed
    logic                       r_s2_valid;
    logic signed [SAMPLE_W-1:0] r_s2_x;
    logic signed [SAMPLE_W-1:0] r_s2_d;
    logic signed [SAMPLE_W-1:0] r_s2_md;
    logic signed [SAMPLE_W-1:0] r_s2_mx;
    logic                       r_s2_neg;
    logic [XW-1:0]              r_s2_w;

    // Last memory write, for forwarding
    logic                r_wb_valid;
    logic [XW-1:0]       r_wb_addr;
    logic [SAMPLE_W-1:0] r_wb_data;

    // Output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic                       cfg_wr;
    t_reg_idx                   cfg_idx;
    logic                       delay_wr;
    logic                       en;
    logic                       hazard;
    logic                       in_acc;
    logic                       mem_wr;
    logic                       filled;
    logic [CFG_W-1:0]           eff_end;
    logic [LEN_W-1:0]           loop_len;
    logic [XW-1:0]              wr_next;
    logic [XW-1:0]              rd_next;
    logic                       fwd_hit;
    logic signed [SAMPLE_W-1:0] s1_delayed;
    logic signed [63:0]         prod_d;
    logic signed [63:0]         prod_x;
    logic signed [SAMPLE_W-1:0] sub_op;
    logic signed [SAMPLE_W-1:0] neg_op;
    logic signed [SAMPLE_W:0]   fb_sum;
    logic signed [SAMPLE_W-1:0] fb;
    logic signed [SAMPLE_W-1:0] y;
    logic [CFG_W-1:0]           rs_rd_idx;
    t_rs_status                 rs_status;

    // Decode the configuration access
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = t_reg_idx'(paddr[3:2]);
    assign delay_wr = cfg_wr && (cfg_idx == REG_DELAY);

    // Clamp the loop end to the memory and advance the indices
    assign eff_end  = (r_loop_end > END_MAX) ? END_MAX : r_loop_end;
    assign loop_len = LEN_W'(eff_end) + LEN_W'(1);
    assign wr_next  = (CFG_W'(r_wr_idx) >= eff_end) ? '0 : (r_wr_idx + XW'(1));
    assign rd_next  = (CFG_W'(r_rd_idx) >= eff_end) ? '0 : (r_rd_idx + XW'(1));

    // Advance the pipeline unless the output word is held; interlock the one-behind read
    assign en      = !r_out_valid || !i_stall;
    assign hazard  = r_s1_valid && (r_s1_w == r_rd_idx);
    assign o_stall = !en || rs_status.busy || hazard || cfg_wr;
    assign in_acc  = i_valid && !o_stall;
    assign mem_wr  = en && r_s2_valid;
    assign filled  = {1'b0, r_rd_idx} < r_fill;

    // Pick the delayed sample: forwarded write, stored word, or zero if never written
    assign fwd_hit    = r_wb_valid && (r_wb_addr == r_s1_r);
    assign s1_delayed = fwd_hit ? signed'(r_wb_data)
                                : (r_s1_filled ? signed'(r_rd_data) : '0);
    assign prod_d     = 64'(s1_delayed) * 64'(r_gain);
    assign prod_x     = 64'(r_s1_x) * 64'(r_gain);

    // Form the saturated feedback word and the wrapping output
    assign sub_op = r_s2_neg ? r_s2_d : r_s2_md;
    assign neg_op = (sub_op == Q31_MIN) ? Q31_MAX : -sub_op;
    assign fb_sum = (SAMPLE_W+1)'(r_s2_x) + (SAMPLE_W+1)'(neg_op);
    assign fb     = (fb_sum[SAMPLE_W] != fb_sum[SAMPLE_W-1])
                  ? (fb_sum[SAMPLE_W] ? Q31_MIN : Q31_MAX)
                  : fb_sum[SAMPLE_W-1:0];
    assign y      = r_s2_d + (r_s2_neg ? r_s2_x : r_s2_mx);

    // Recompute the read index after a delay write
    adf_resync u_resync (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (delay_wr),
        .i_delay  (pwdata[CFG_W-1:0]),
        .i_len    (loop_len),
        .i_wr_idx (CFG_W'(r_wr_idx)),
        .o_rd_idx (rs_rd_idx),
        .o_status (rs_status)
    );

    // Read back registers
    always_comb begin
        case (cfg_idx)
            REG_GAIN:     prdata = r_gain;
            REG_DELAY:    prdata = 32'(r_delay);
            REG_LOOP_END: prdata = 32'(r_loop_end);
            default:      prdata = '0;
        endcase
    end

    // Write and read the delay memory
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[AW'(r_s2_w)] <= fb;
        end
        if (en) begin
            r_rd_data <= r_mem[AW'(r_rd_idx)];
        end
    end

    // Control state: registers, indices, fill count, valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= '0;
            r_delay     <= '0;
            r_loop_end  <= LOOP_END_RESET;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wb_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_GAIN:     r_gain     <= signed'(pwdata);
                    REG_DELAY:    r_delay    <= pwdata[CFG_W-1:0];
                    REG_LOOP_END: r_loop_end <= pwdata[CFG_W-1:0];
                    default:      r_gain     <= r_gain;
                endcase
            end
            if (in_acc) begin
                r_wr_idx <= wr_next;
                r_rd_idx <= rd_next;
            end else if (rs_status.done) begin
                r_rd_idx <= rs_rd_idx[XW-1:0];
            end
            if (mem_wr) begin
                r_wb_valid <= 1'b1;
                if ({1'b0, r_s2_w} == r_fill) begin
                    r_fill <= r_fill + (XW+1)'(1);
                end
            end
            if (en) begin
                r_s1_valid  <= in_acc;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // Payload: advance the stages
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_x      <= i_sample_in;
            r_s1_w      <= r_wr_idx;
            r_s1_r      <= r_rd_idx;
            r_s1_filled <= filled;
        end
        if (en && r_s1_valid) begin
            r_s2_x   <= r_s1_x;
            r_s2_d   <= s1_delayed;
            r_s2_md  <= prod_d[62:31];
            r_s2_mx  <= prod_x[62:31];
            r_s2_neg <= r_gain[SAMPLE_W-1];
            r_s2_w   <= r_s1_w;
        end
        if (mem_wr) begin
            r_wb_addr  <= r_s2_w;
            r_wb_data  <= fb;
            r_out_data <= y;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_data;

`ifndef SYNTHESIS
    // Written entries always form a prefix of the memory
    a_fill_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr |-> ({1'b0, r_s2_w} <= r_fill))
        else $error("delay memory write beyond the filled prefix");

    // The word being formed never writes the entry the next word has just read
    a_no_raw_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s2_valid) |-> (r_s2_w != r_s1_r))
        else $error("read of an entry with a write still in flight");

    // A delay write holds off input until the read index is recomputed
    a_resync_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        delay_wr |=> o_stall)
        else $error("input accepted while read index is being recomputed");

    // The recomputed read index is taken
    a_resync_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rs_status.done |=> (r_rd_idx == $past(rs_rd_idx[XW-1:0])))
        else $error("recomputed read index not loaded");
`endif

endmodule
